/* hdl/assert_macros.svh */
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is low
`define UERF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define UERF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/uerf_pkg.sv */
// types, codes and field masks of the usb endpoint register file
package uerf_pkg;

  localparam int unsigned EP_W   = 3;
  localparam int unsigned WORD_W = 16;

  localparam logic [WORD_W-1:0] F_CTR_RX  = 16'h8000;
  localparam logic [WORD_W-1:0] F_DTOG_RX = 16'h4000;
  localparam logic [WORD_W-1:0] F_STAT_RX = 16'h3000;
  localparam logic [WORD_W-1:0] F_SETUP   = 16'h0800;
  localparam logic [WORD_W-1:0] F_TYPE    = 16'h0600;
  localparam logic [WORD_W-1:0] F_KIND    = 16'h0100;
  localparam logic [WORD_W-1:0] F_CTR_TX  = 16'h0080;
  localparam logic [WORD_W-1:0] F_DTOG_TX = 16'h0040;
  localparam logic [WORD_W-1:0] F_STAT_TX = 16'h0030;
  localparam logic [WORD_W-1:0] F_ADDR    = 16'h000F;
  localparam logic [WORD_W-1:0] STAT_RX_NAK = 16'h2000;
  localparam logic [WORD_W-1:0] STAT_TX_NAK = 16'h0020;
  localparam logic [WORD_W-1:0] ISTR_ANY    = 16'h8000;
  localparam logic [WORD_W-1:0] ISTR_DIR    = 16'h0010;

  typedef enum logic [1:0] {
    MODE_READ_EP   = 2'd0,
    MODE_WRITE_EP  = 2'd1,
    MODE_READ_ISTR = 2'd2,
    MODE_TRANSACT  = 2'd3
  } uerf_mode_t;

  typedef enum logic [1:0] {
    TOK_OUT   = 2'd0,
    TOK_IN    = 2'd1,
    TOK_SETUP = 2'd2
  } uerf_token_t;

  typedef enum logic [1:0] {
    HS_NONE  = 2'd0,
    HS_ACK   = 2'd1,
    HS_NAK   = 2'd2,
    HS_STALL = 2'd3
  } uerf_hs_t;

  typedef enum logic [1:0] {
    STAT_DISABLED = 2'd0,
    STAT_STALL    = 2'd1,
    STAT_NAK      = 2'd2,
    STAT_VALID    = 2'd3
  } uerf_stat_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } uerf_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } uerf_cmd_t;

  typedef struct packed {
    logic out_stall;
  } uerf_sts_t;

  // answer of a direction that is not valid
  function automatic uerf_hs_t stat_answer(input logic [1:0] stat);
    uerf_hs_t hs;
    case (uerf_stat_t'(stat))
      STAT_NAK:   hs = HS_NAK;
      STAT_STALL: hs = HS_STALL;
      default:    hs = HS_NONE;
    endcase
    return hs;
  endfunction

endpackage

/* hdl/usb_endpoint_register_file_unit.sv */
// Endpoint register bank of a full-speed usb device: register reads and writes,
// interrupt status reads and bus transactions, one result per request. A request
// is captured in the cycle it is accepted and then executed as one read-modify-write
// of at most one endpoint register; no new request is taken until it has executed,
// and the execute cycle waits while the previous result sits untaken in the
// output register. The endpoint registers reset to zero with the synchronous reset.
`include "assert_macros.svh"

module usb_endpoint_register_file_unit #(
  parameter int unsigned ENDPOINTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_endpoint,
  input  logic [15:0] in_write_data,
  input  logic [1:0]  in_token_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic [1:0]  out_handshake,
  output logic        out_transfer_pending
);

  uerf_pkg::uerf_cmd_t cmd;
  uerf_pkg::uerf_sts_t sts;

  uerf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uerf_datapath #(
    .ENDPOINTS (ENDPOINTS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_mode              (in_mode),
    .in_endpoint          (in_endpoint),
    .in_write_data        (in_write_data),
    .in_token_kind        (in_token_kind),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_read_data        (out_read_data),
    .out_handshake        (out_handshake),
    .out_transfer_pending (out_transfer_pending)
  );

  `UERF_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "request accepted while executing")
  `UERF_ASSERT(a_commit_free, cmd.commit |-> (!out_valid || out_ready), "result overwrites an untaken result")
  `UERF_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

/* hdl/uerf_ctrl.sv */
// controller: request capture and execute sequencing
module uerf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uerf_pkg::uerf_sts_t sts,
  output uerf_pkg::uerf_cmd_t cmd
);

  uerf_pkg::uerf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uerf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      uerf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = uerf_pkg::ST_EXEC;
        end
      end
      uerf_pkg::ST_EXEC: begin
        if (!sts.out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = uerf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = uerf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/uerf_datapath.sv */
// datapath: endpoint registers, update rules, status word and result register
module uerf_datapath #(
  parameter int unsigned ENDPOINTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  uerf_pkg::uerf_cmd_t cmd,
  output uerf_pkg::uerf_sts_t sts,
  input  logic [1:0]          in_mode,
  input  logic [2:0]          in_endpoint,
  input  logic [15:0]         in_write_data,
  input  logic [1:0]          in_token_kind,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_read_data,
  output logic [1:0]          out_handshake,
  output logic                out_transfer_pending
);

  localparam int unsigned IDX_W = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
  localparam int unsigned W     = uerf_pkg::WORD_W;
  localparam logic [W-1:0] M_PLAIN = uerf_pkg::F_TYPE | uerf_pkg::F_KIND | uerf_pkg::F_ADDR;
  localparam logic [W-1:0] M_TOG   = uerf_pkg::F_DTOG_RX | uerf_pkg::F_STAT_RX
                                   | uerf_pkg::F_DTOG_TX | uerf_pkg::F_STAT_TX;
  localparam logic [W-1:0] M_CTR   = uerf_pkg::F_CTR_RX | uerf_pkg::F_CTR_TX;

  logic [W-1:0]          regs_r [ENDPOINTS];
  uerf_pkg::uerf_mode_t  mode_r;
  logic [uerf_pkg::EP_W-1:0] ep_r;
  logic [W-1:0]          wd_r;
  uerf_pkg::uerf_token_t tok_r;
  logic                  out_valid_r;
  logic [W-1:0]          rd_r;
  uerf_pkg::uerf_hs_t    hs_r;
  logic                  pend_r;

  logic                  ok;
  logic [IDX_W-1:0]      idx;
  logic [W-1:0]          old_w;
  logic [W-1:0]          new_w;
  logic                  wr_en;
  uerf_pkg::uerf_hs_t    hs_nxt;
  logic [W-1:0]          rd_nxt;
  logic [W-1:0]          istr;
  logic                  pend_nxt;
  logic [W-1:0]          view;

  assign ok    = ({29'd0, ep_r} < ENDPOINTS);
  assign idx   = ep_r[IDX_W-1:0];
  assign old_w = ok ? regs_r[idx] : '0;

  // interrupt status word from the current registers, lowest endpoint wins
  always_comb begin
    istr = '0;
    for (int i = ENDPOINTS - 1; i >= 0; i--) begin
      if ((regs_r[i] & M_CTR) != '0) begin
        istr = uerf_pkg::ISTR_ANY | {12'd0, 4'(i)}
             | (((regs_r[i] & uerf_pkg::F_CTR_RX) != '0) ? uerf_pkg::ISTR_DIR : '0);
      end
    end
  end

  // register update and answer for the request held in the capture register
  always_comb begin
    new_w  = old_w;
    wr_en  = 1'b0;
    hs_nxt = uerf_pkg::HS_NONE;
    rd_nxt = '0;
    case (mode_r)
      uerf_pkg::MODE_READ_EP: begin
        rd_nxt = old_w;
      end
      uerf_pkg::MODE_WRITE_EP: begin
        wr_en = ok;
        new_w = (wd_r & M_PLAIN) | ((old_w ^ wd_r) & M_TOG)
              | (old_w & wd_r & M_CTR) | (old_w & uerf_pkg::F_SETUP);
      end
      uerf_pkg::MODE_READ_ISTR: begin
        rd_nxt = istr;
      end
      uerf_pkg::MODE_TRANSACT: begin
        if (ok) begin
          if (tok_r inside {uerf_pkg::TOK_OUT, uerf_pkg::TOK_SETUP}) begin
            if (uerf_pkg::uerf_stat_t'(old_w[13:12]) == uerf_pkg::STAT_VALID) begin
              wr_en  = 1'b1;
              hs_nxt = uerf_pkg::HS_ACK;
              new_w  = ((old_w & ~uerf_pkg::F_STAT_RX) | uerf_pkg::STAT_RX_NAK);
              new_w  = (new_w ^ uerf_pkg::F_DTOG_RX) | uerf_pkg::F_CTR_RX;
              if (tok_r == uerf_pkg::TOK_SETUP) begin
                new_w = new_w | uerf_pkg::F_SETUP;
              end else begin
                new_w = new_w & ~uerf_pkg::F_SETUP;
              end
            end else begin
              hs_nxt = uerf_pkg::stat_answer(old_w[13:12]);
            end
          end else if (tok_r == uerf_pkg::TOK_IN) begin
            if (uerf_pkg::uerf_stat_t'(old_w[5:4]) == uerf_pkg::STAT_VALID) begin
              wr_en  = 1'b1;
              hs_nxt = uerf_pkg::HS_ACK;
              new_w  = ((old_w & ~uerf_pkg::F_STAT_TX) | uerf_pkg::STAT_TX_NAK);
              new_w  = (new_w ^ uerf_pkg::F_DTOG_TX) | uerf_pkg::F_CTR_TX;
            end else begin
              hs_nxt = uerf_pkg::stat_answer(old_w[5:4]);
            end
          end
        end
      end
      default: begin
        rd_nxt = '0;
      end
    endcase
  end

  // pending flag after this request's update
  always_comb begin
    pend_nxt = 1'b0;
    view     = '0;
    for (int i = 0; i < ENDPOINTS; i++) begin
      view = (wr_en && (ep_r == uerf_pkg::EP_W'(i))) ? new_w : regs_r[i];
      if ((view & M_CTR) != '0) begin
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= uerf_pkg::uerf_mode_t'(in_mode);
      ep_r   <= in_endpoint;
      wd_r   <= in_write_data;
      tok_r  <= uerf_pkg::uerf_token_t'(in_token_kind);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENDPOINTS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (cmd.commit && wr_en) begin
      regs_r[idx] <= new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rd_r   <= rd_nxt;
      hs_r   <= hs_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign sts.out_stall        = out_valid_r && !out_ready;
  assign out_valid            = out_valid_r;
  assign out_read_data        = rd_r;
  assign out_handshake        = hs_r;
  assign out_transfer_pending = pend_r;

endmodule

/* tb/sv/uerf_result_check.sv */
// predicts and checks the results of the usb endpoint register file from its two channels
module uerf_result_check
  import uerf_pkg::*;
#(
  parameter int unsigned NUM_EPS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_endpoint,
  input  logic [15:0] in_write_data,
  input  logic [1:0]  in_token_kind,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_read_data,
  input  logic [1:0]  out_handshake,
  input  logic        out_transfer_pending,
  output int          fail_count,
  output int          open_count,
  output int          checked_count
);

  typedef struct packed {
    logic [15:0] read_data;
    uerf_hs_t    handshake;
    logic        pending;
  } ep_result_t;

  logic [15:0] ep_state [NUM_EPS];
  ep_result_t  result_q [$];
  int          errs;
  int          seen;

  function automatic logic [15:0] written_word(input logic [15:0] old, input logic [15:0] w);
    logic [15:0] plain;
    logic [15:0] tog;
    logic [15:0] ctr;
    plain = w & (F_TYPE | F_KIND | F_ADDR);
    tog   = (old ^ w) & (F_DTOG_RX | F_STAT_RX | F_DTOG_TX | F_STAT_TX);
    ctr   = old & w & (F_CTR_RX | F_CTR_TX);
    return plain | tog | ctr | (old & F_SETUP);
  endfunction

  function automatic logic [15:0] istr_word();
    logic [15:0] word;
    logic        found;
    word  = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_EPS; i++) begin
      if (!found && (ep_state[i] & (F_CTR_RX | F_CTR_TX)) != '0) begin
        found = 1'b1;
        word  = ISTR_ANY | 16'(i[3:0]);
        if ((ep_state[i] & F_CTR_RX) != '0) word = word | ISTR_DIR;
      end
    end
    return word;
  endfunction

  function automatic uerf_hs_t nak_or_stall(input logic [1:0] st);
    uerf_hs_t hs;
    case (st)
      STAT_NAK:   hs = HS_NAK;
      STAT_STALL: hs = HS_STALL;
      default:    hs = HS_NONE;
    endcase
    return hs;
  endfunction

  function automatic uerf_hs_t bus_answer(input int ep, input logic [1:0] tok);
    logic [15:0] r;
    uerf_hs_t    hs;
    r  = ep_state[ep];
    hs = HS_ACK;
    if (tok == TOK_OUT || tok == TOK_SETUP) begin
      if (r[13:12] != STAT_VALID) begin
        hs = nak_or_stall(r[13:12]);
      end else begin
        r = (r & ~F_STAT_RX) | STAT_RX_NAK;
        r = (r ^ F_DTOG_RX) | F_CTR_RX;
        if (tok == TOK_SETUP) r = r | F_SETUP;
        else r = r & ~F_SETUP;
      end
    end else if (tok == TOK_IN) begin
      if (r[5:4] != STAT_VALID) begin
        hs = nak_or_stall(r[5:4]);
      end else begin
        r = (r & ~F_STAT_TX) | STAT_TX_NAK;
        r = (r ^ F_DTOG_TX) | F_CTR_TX;
      end
    end else begin
      hs = HS_NONE;
    end
    if (hs == HS_ACK) ep_state[ep] = r;
    return hs;
  endfunction

  function automatic ep_result_t predict_result(input logic [1:0] mode, input int ep,
                                                input logic [15:0] wd, input logic [1:0] tok);
    ep_result_t  res;
    logic        in_range;
    logic [15:0] istr_now;
    in_range      = ep < NUM_EPS;
    res.read_data = '0;
    res.handshake = HS_NONE;
    case (mode)
      MODE_READ_EP:   if (in_range) res.read_data = ep_state[ep];
      MODE_WRITE_EP:  if (in_range) ep_state[ep] = written_word(ep_state[ep], wd);
      MODE_READ_ISTR: res.read_data = istr_word();
      default:        if (in_range) res.handshake = bus_answer(ep, tok);
    endcase
    istr_now    = istr_word();
    res.pending = istr_now[15];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on %s: got %h, expected %h (result %0d)", field, got, want, seen);
    errs++;
  endtask

  always @(posedge clk) begin
    ep_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_EPS; i++) ep_state[i] = '0;
      result_q.delete();
      errs = 0;
      seen = 0;
    end else begin
      if (in_valid && in_ready)
        result_q.push_back(predict_result(in_mode, int'(in_endpoint), in_write_data,
                                          in_token_kind));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", out_read_data, '0);
        end else begin
          want = result_q.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", out_read_data, want.read_data);
          if (out_handshake !== want.handshake)
            report_mismatch("handshake", 16'(out_handshake), 16'(want.handshake));
          if (out_transfer_pending !== want.pending)
            report_mismatch("transfer_pending", 16'(out_transfer_pending), 16'(want.pending));
        end
        seen++;
      end
    end
    fail_count    <= errs;
    open_count    <= result_q.size();
    checked_count <= seen;
  end

endmodule

/* tb/sv/usb_endpoint_register_file_unit_tb.sv */
// stimulus and verdict for the usb endpoint register file, checked beside the block
module usb_endpoint_register_file_unit_tb;
  import uerf_pkg::*;

  localparam logic [1:0] TOK_BAD = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_READ_EP;
  logic [2:0]  in_endpoint = '0;
  logic [15:0] in_write_data = '0;
  logic [1:0]  in_token_kind = TOK_OUT;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_read_data;
  logic [1:0]  out_handshake;
  logic        out_transfer_pending;

  int fail_count;
  int open_count;
  int checked_count;
  int snd_idle = 0;
  int rcv_idle = 0;
  int sent = 0;

  usb_endpoint_register_file_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_endpoint          (in_endpoint),
    .in_write_data        (in_write_data),
    .in_token_kind        (in_token_kind),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_read_data        (out_read_data),
    .out_handshake        (out_handshake),
    .out_transfer_pending (out_transfer_pending)
  );

  uerf_result_check u_result_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_endpoint          (in_endpoint),
    .in_write_data        (in_write_data),
    .in_token_kind        (in_token_kind),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_read_data        (out_read_data),
    .out_handshake        (out_handshake),
    .out_transfer_pending (out_transfer_pending),
    .fail_count           (fail_count),
    .open_count           (open_count),
    .checked_count        (checked_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // called at a rising edge, returns at the edge that accepts the request
  task automatic send_request(input logic [1:0] mode, input logic [2:0] ep,
                              input logic [15:0] wd, input logic [1:0] tok);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_endpoint   <= ep;
    in_write_data <= wd;
    in_token_kind <= tok;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic random_request();
    int          pick;
    logic [1:0]  mode;
    logic [1:0]  tok;
    logic [15:0] wd;
    pick = $urandom_range(99);
    if (pick < 30) mode = MODE_WRITE_EP;
    else if (pick < 65) mode = MODE_TRANSACT;
    else if (pick < 85) mode = MODE_READ_EP;
    else mode = MODE_READ_ISTR;
    pick = $urandom_range(99);
    if (pick < 35) tok = TOK_OUT;
    else if (pick < 70) tok = TOK_IN;
    else if (pick < 94) tok = TOK_SETUP;
    else tok = TOK_BAD;
    wd = 16'($urandom);
    // driver-style writes: mostly keep flags, touch only some toggle bits
    if ($urandom_range(1) == 1)
      wd = (wd & ~(F_DTOG_RX | F_STAT_RX | F_DTOG_TX | F_STAT_TX))
         | (wd & 16'($urandom) & 16'($urandom))
         | (($urandom_range(3) != 0) ? (F_CTR_RX | F_CTR_TX) : 16'h0000);
    send_request(mode, 3'($urandom_range(7)), wd, tok);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle = 9;
    rcv_idle = 45;
    send_request(MODE_READ_EP,   3'd0, 16'h0000, TOK_OUT);
    send_request(MODE_READ_ISTR, 3'd0, 16'h0000, TOK_OUT);
    send_request(MODE_WRITE_EP,  3'd7, 16'hFFFF, TOK_OUT);
    send_request(MODE_READ_EP,   3'd7, 16'h0000, TOK_OUT);
    send_request(MODE_TRANSACT,  3'd7, 16'h0000, TOK_OUT);
    send_request(MODE_TRANSACT,  3'd7, 16'h0000, TOK_IN);
    send_request(MODE_TRANSACT,  3'd7, 16'h0000, TOK_SETUP);
    send_request(MODE_READ_ISTR, 3'd0, 16'h0000, TOK_OUT);
    send_request(MODE_WRITE_EP,  3'd3, 16'h3000, TOK_OUT);
    send_request(MODE_TRANSACT,  3'd3, 16'h0000, TOK_SETUP);
    send_request(MODE_READ_EP,   3'd3, 16'h0000, TOK_OUT);
    send_request(MODE_READ_ISTR, 3'd0, 16'h0000, TOK_OUT);
    send_request(MODE_WRITE_EP,  3'd3, 16'h0800, TOK_OUT);
    send_request(MODE_READ_EP,   3'd3, 16'h0000, TOK_OUT);
    send_request(MODE_WRITE_EP,  3'd2, 16'h1010, TOK_OUT);
    send_request(MODE_TRANSACT,  3'd2, 16'h0000, TOK_OUT);
    send_request(MODE_TRANSACT,  3'd2, 16'h0000, TOK_IN);
    send_request(MODE_TRANSACT,  3'd0, 16'h0000, TOK_OUT);
    send_request(MODE_TRANSACT,  3'd7, 16'h0000, TOK_BAD);
    send_request(MODE_WRITE_EP,  3'd7, 16'h8080, TOK_OUT);
    send_request(MODE_READ_EP,   3'd7, 16'h0000, TOK_OUT);
    send_request(MODE_WRITE_EP,  3'd7, 16'h0000, TOK_OUT);
    send_request(MODE_WRITE_EP,  3'd5, 16'h0030, TOK_OUT);
    send_request(MODE_TRANSACT,  3'd5, 16'h0000, TOK_IN);
    send_request(MODE_READ_ISTR, 3'd0, 16'h0000, TOK_OUT);

    repeat (150) random_request();
    snd_idle = 45;
    rcv_idle = 9;
    repeat (150) random_request();
    snd_idle = 0;
    rcv_idle = 0;
    repeat (150) random_request();

    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("summary: %0d requests (register reads, writes, status reads, bus tokens)",
             sent);
    $display("summary: %0d results compared over three back-pressure phases", checked_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
